/* hdl/was_pkg.sv */
`timescale 1ns / 1ps
// Package: constants, opcodes and helpers for the weekly alarm scheduler.
package was_pkg;

  localparam int unsigned SlotCount = 5;
  localparam int unsigned SlotW     = 3;
  localparam int unsigned DayW      = 3;
  localparam int unsigned RegW      = 19;
  localparam int unsigned MinW      = 15;   // minutes of week incl. overflow
  localparam int unsigned DistW     = 14;   // corrected distance, below 16384

  localparam logic [MinW-1:0]  MinPerWeek = 15'd10080;
  localparam logic [DayW-1:0]  LastDay    = 3'd6;
  localparam logic [SlotW-1:0] LastSlot   = 3'd4;

  // register fields
  localparam int unsigned EnBit    = 18;
  localparam int unsigned MaskLsb  = 11;
  localparam int unsigned HourLsb  = 6;

  // config register indexes
  localparam logic [SlotW-1:0] CfgAlarmZero  = 3'd0;
  localparam logic [SlotW-1:0] CfgAlarmOne   = 3'd1;
  localparam logic [SlotW-1:0] CfgAlarmTwo   = 3'd2;
  localparam logic [SlotW-1:0] CfgAlarmThree = 3'd3;
  localparam logic [SlotW-1:0] CfgAlarmFour  = 3'd4;

  localparam logic [SlotCount-1:0][RegW-1:0] AlarmReset = {
    19'd1, 19'd896, 19'd129932, 19'd8304, 19'd1453
  };

  // opcodes
  localparam logic [1:0] OpTick      = 2'd0;
  localparam logic [1:0] OpRecompute = 2'd1;
  localparam logic [1:0] OpStop      = 2'd2;

  // day * 1440; day seven gives a full week
  function automatic logic [MinW-1:0] day_offset(input logic [DayW-1:0] day);
    logic [MinW-1:0] off;
    unique case (day)
      3'd0: off = 15'd0;
      3'd1: off = 15'd1440;
      3'd2: off = 15'd2880;
      3'd3: off = 15'd4320;
      3'd4: off = 15'd5760;
      3'd5: off = 15'd7200;
      3'd6: off = 15'd8640;
      default: off = 15'd10080;
    endcase
    return off;
  endfunction

  // hour * 60 + minute
  function automatic logic [MinW-1:0] time_of_day(input logic [4:0] hour,
                                                   input logic [6:0] minute);
    logic [MinW-1:0] h;
    h = MinW'(hour);
    return (h << 6) - (h << 2) + MinW'(minute);
  endfunction

endpackage

/* hdl/weekly_alarm_scheduler_core.sv */
`timescale 1ns / 1ps
// Weekly alarm scheduler core: alarm registers, tick match and sequential next-alarm scan.
// Flow: an accepted item passes evaluate, then output; a scan puts 35 alarm-day pairs, one per
// cycle through a shared subtract/compare unit, and then finish between evaluate and output.
// Accept: no new item until the last result is registered; a stalled output holds the next
// result in its last state, which then blocks the item after that.
// Reset (rst_ni low, async) loads alarm reset values, clears choice and ringing; no scan runs.
module weekly_alarm_scheduler_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // opcode[1:0], now_hour[6:2], now_minute[12:7], now_second[18:13],
  // now_weekday[21:19], zero fill[23:22]
  input  logic [23:0] s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // ringing[0], ring_started[1], ring_stopped[2], next_valid[3],
  // next_slot[6:4], zero fill[7]
  output logic [7:0]  m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [18:0] cfg_wdata_i
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StEval = 3'd1;
  localparam logic [2:0] StScan = 3'd2;
  localparam logic [2:0] StFin  = 3'd3;
  localparam logic [2:0] StDone = 3'd4;

  logic [2:0] state_q, state_d;

  logic [was_pkg::SlotCount-1:0][was_pkg::RegW-1:0] alarm_q;

  // latched item
  logic [1:0] op_q;
  logic [4:0] hour_q;
  logic [5:0] minute_q;
  logic [5:0] second_q;
  logic [2:0] day_q;

  logic [was_pkg::SlotW-1:0] chosen_slot_q, chosen_slot_d;
  logic                      chosen_valid_q, chosen_valid_d;
  logic                      ring_q, ring_d;
  logic                      started_q, started_d;
  logic                      stopped_q, stopped_d;

  logic [was_pkg::MinW-1:0]  now_q, now_d;
  logic [was_pkg::SlotW-1:0] scan_slot_q, scan_slot_d;
  logic [was_pkg::DayW-1:0]  scan_day_q, scan_day_d;
  logic                      found_q, found_d;
  logic [was_pkg::DistW-1:0] best_q, best_d;
  logic [was_pkg::SlotW-1:0] pick_q, pick_d;

  logic [7:0] out_data_q, out_data_d;
  logic       out_valid_q, out_valid_d;

  // single read port into the alarm registers
  logic [was_pkg::SlotW-1:0] rd_sel;
  logic [was_pkg::RegW-1:0]  rd_reg;
  logic [7:0]                mask8;
  logic                      match;

  // shared distance unit
  logic [was_pkg::MinW-1:0] alarm_min;
  logic signed [15:0]       dist_raw, dist_1, dist_2;
  logic [was_pkg::DistW-1:0] dist_wrap;
  logic                      cand;

  assign rd_sel = (state_q == StScan) ? scan_slot_q : chosen_slot_q;
  assign rd_reg = (rd_sel <= was_pkg::LastSlot) ? alarm_q[rd_sel] : '0;
  assign mask8  = {1'b0, rd_reg[was_pkg::EnBit-1:was_pkg::MaskLsb]};

  assign match = chosen_valid_q && mask8[day_q]
              && (rd_reg[was_pkg::EnBit-8:was_pkg::HourLsb] == hour_q)
              && (rd_reg[was_pkg::HourLsb-1:0] == minute_q);

  assign alarm_min = was_pkg::time_of_day(rd_reg[10:6], {1'b0, rd_reg[5:0]})
                   + was_pkg::day_offset(scan_day_q);
  assign dist_raw  = $signed({1'b0, alarm_min}) - $signed({1'b0, now_q});
  assign dist_1    = dist_raw[15] ? dist_raw + $signed({1'b0, was_pkg::MinPerWeek})
                                  : dist_raw;
  assign dist_2    = dist_1[15] ? dist_1 + $signed({1'b0, was_pkg::MinPerWeek}) : dist_1;
  assign dist_wrap = dist_2[was_pkg::DistW-1:0];
  assign cand      = rd_reg[was_pkg::EnBit] && mask8[scan_day_q];

  always_comb begin
    state_d        = state_q;
    chosen_slot_d  = chosen_slot_q;
    chosen_valid_d = chosen_valid_q;
    ring_d         = ring_q;
    started_d      = started_q;
    stopped_d      = stopped_q;
    now_d          = now_q;
    scan_slot_d    = scan_slot_q;
    scan_day_d     = scan_day_q;
    found_d        = found_q;
    best_d         = best_q;
    pick_d         = pick_q;
    out_data_d     = out_data_q;
    out_valid_d    = out_valid_q && !m_axis_tready;

    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          started_d = 1'b0;
          stopped_d = 1'b0;
          state_d   = StEval;
        end
      end
      StEval: begin
        now_d = was_pkg::time_of_day(hour_q, 7'(minute_q) + 7'd1)
              + was_pkg::day_offset(day_q);
        scan_slot_d = '0;
        scan_day_d  = '0;
        found_d     = 1'b0;
        best_d      = '0;
        pick_d      = '0;
        state_d     = StDone;
        unique case (op_q)
          was_pkg::OpTick: begin
            if ((match && (second_q == 6'd0)) || ring_q) begin
              if (match) begin
                ring_d    = 1'b1;
                started_d = !ring_q;
              end else begin
                ring_d    = 1'b0;
                stopped_d = 1'b1;
                state_d   = StScan;
              end
            end
          end
          was_pkg::OpRecompute: state_d = StScan;
          was_pkg::OpStop: begin
            stopped_d = ring_q;
            ring_d    = 1'b0;
            state_d   = StScan;
          end
          default: state_d = StDone;
        endcase
      end
      StScan: begin
        if (cand && (!found_q || (dist_wrap < best_q))) begin
          found_d = 1'b1;
          best_d  = dist_wrap;
          pick_d  = scan_slot_q;
        end
        if (scan_day_q == was_pkg::LastDay) begin
          scan_day_d  = '0;
          scan_slot_d = scan_slot_q + 3'd1;
          if (scan_slot_q == was_pkg::LastSlot) state_d = StFin;
        end else begin
          scan_day_d = scan_day_q + 3'd1;
        end
      end
      StFin: begin
        chosen_valid_d = found_q;
        chosen_slot_d  = found_q ? pick_q : '0;
        state_d        = StDone;
      end
      StDone: begin
        if (!out_valid_q || m_axis_tready) begin
          out_data_d  = {1'b0, chosen_valid_q ? chosen_slot_q : 3'd0, chosen_valid_q,
                         stopped_q, started_q, ring_q};
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      alarm_q        <= was_pkg::AlarmReset;
      chosen_slot_q  <= '0;
      chosen_valid_q <= 1'b0;
      ring_q         <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      chosen_slot_q  <= chosen_slot_d;
      chosen_valid_q <= chosen_valid_d;
      ring_q         <= ring_d;
      out_valid_q    <= out_valid_d;
      if (cfg_we_i && (cfg_idx_i <= was_pkg::CfgAlarmFour)) begin
        alarm_q[cfg_idx_i] <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    started_q   <= started_d;
    stopped_q   <= stopped_d;
    now_q       <= now_d;
    scan_slot_q <= scan_slot_d;
    scan_day_q  <= scan_day_d;
    found_q     <= found_d;
    best_q      <= best_d;
    pick_q      <= pick_d;
    out_data_q  <= out_data_d;
    if (s_axis_tvalid && s_axis_tready) begin
      op_q     <= s_axis_tdata[1:0];
      hour_q   <= s_axis_tdata[6:2];
      minute_q <= s_axis_tdata[12:7];
      second_q <= s_axis_tdata[18:13];
      day_q    <= s_axis_tdata[21:19];
    end
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tvalid = out_valid_q;

endmodule
